// File: design/botp_pkg.sv
// ----------------------------------------------------------------------------
// botp_pkg - shared definitions for the byte order test pattern pixel block
// Field widths, register indexes, pattern constants and the color/pack helpers.
// ----------------------------------------------------------------------------
package botp_pkg;

    localparam int PIX_W      = 10;
    localparam int BYTES_W    = 32;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    // depth mode codes
    localparam logic DEPTH_16 = 1'b0;
    localparam logic DEPTH_32 = 1'b1;

    // default geometry
    localparam int DEF_SCREEN_WIDTH      = 1024;
    localparam int DEF_SCREEN_HEIGHT     = 768;
    localparam int DEF_MARKER_STRIP_ROWS = 64;
    localparam int DEF_COLUMN_GAP        = 8;

    // marker squares
    localparam int MARK_Y0    = 16;
    localparam int MARK_Y1    = 48;
    localparam int MARK_X0    = 16;
    localparam int MARK_PITCH = 48;
    localparam int MARK_SIZE  = 32;
    localparam int MAX_COLS   = 4;

    localparam int CH_MAX     = 255;
    localparam int BAND_COUNT = 5;

    // ramp divide by reciprocal: numerator is cx*255, at most PIX_W+8 bits
    localparam int NUM_W      = PIX_W + CH_W;
    localparam int RAMP_SHIFT = NUM_W;
    localparam int RECIP_W    = RAMP_SHIFT + 1;

    typedef logic [CH_W-1:0] t_chan;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    localparam t_chan CHAN_FULL = CH_W'(CH_MAX);

    // solid bands: red, green, blue, white
    function automatic t_rgb band_color(input logic [1:0] band);
        t_rgb res;
        res = '0;
        case (band)
            2'd0: res.red = CHAN_FULL;
            2'd1: res.green = CHAN_FULL;
            2'd2: res.blue = CHAN_FULL;
            default: res = '{red: CHAN_FULL, green: CHAN_FULL, blue: CHAN_FULL};
        endcase
        return res;
    endfunction

    // byte 0 in bits 7:0
    function automatic logic [BYTES_W-1:0] pack_pixel(input logic depth,
                                                      input logic [1:0] col,
                                                      input t_rgb c);
        logic [15:0]        w;
        logic [BYTES_W-1:0] res;
        w = {c.red[7:3], c.green[7:2], c.blue[7:3]};
        if (depth == DEPTH_16) begin
            res = (col == 2'd0) ? {16'd0, w} : {16'd0, w[7:0], w[15:8]};
        end else begin
            case (col)
                2'd0: res = {8'd0, c.red, c.green, c.blue};
                2'd1: res = {c.blue, c.green, c.red, 8'd0};
                2'd2: res = {8'd0, c.blue, c.green, c.red};
                default: res = {c.red, c.green, c.blue, 8'd0};
            endcase
        end
        return res;
    endfunction

endpackage

// File: design/botp_if.sv
// ----------------------------------------------------------------------------
// botp_if - channel interfaces of the test pattern pixel block
// Pixel coordinate in, packed pixel out, and the register write channel.
// ----------------------------------------------------------------------------
interface botp_in_if;
    import botp_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    modport source(output valid, output pixel_x, output pixel_y, input ready);
    modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface botp_out_if;
    import botp_pkg::*;
    logic               valid;
    logic               ready;
    logic [BYTES_W-1:0] pixel_bytes;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    modport source(output valid, output pixel_bytes, output red, output green,
                   output blue, input ready);
    modport sink(input valid, input pixel_bytes, input red, input green,
                 input blue, output ready);
endinterface

interface botp_cfg_if;
    import botp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// File: design/byte_order_test_pattern_pixel.sv
// ----------------------------------------------------------------------------
// byte_order_test_pattern_pixel - test pattern pixel generator
// Maps a pixel coordinate to its color and packed bytes (RGB565 or 32 bpp,
// byte order chosen per picture column).
// ----------------------------------------------------------------------------
//  channel  | dir | payload                          | accepted when
//  i_pix    | in  | pixel_x, pixel_y                 | valid && ready
//  o_pix    | out | pixel_bytes, red, green, blue    | valid && ready
//  i_cfg    | in  | index, data                      | valid && ready (ready=1)
//
//  One item per clock while o_pix is not stalled; items cross six register
//  stages (column find, column offset, marker/scale, reciprocal multiply,
//  back multiply, correct and pack). Stage 6 is the output register.
//  Reset clears valid bits, depth_mode to 16 bpp, column_count to 2.
//  A stall backs up stage by stage; empty stages still take items.
// ----------------------------------------------------------------------------
module byte_order_test_pattern_pixel #(
    parameter int SCREEN_WIDTH      = botp_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT     = botp_pkg::DEF_SCREEN_HEIGHT,
    parameter int MARKER_STRIP_ROWS = botp_pkg::DEF_MARKER_STRIP_ROWS,
    parameter int COLUMN_GAP        = botp_pkg::DEF_COLUMN_GAP
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    botp_cfg_if.sink   i_cfg,
    botp_in_if.sink    i_pix,
    botp_out_if.source o_pix
);
    import botp_pkg::*;

    localparam int NST = 6;

    // column geometry per column count
    localparam int CWS1 = SCREEN_WIDTH;
    localparam int CWS2 = (SCREEN_WIDTH - COLUMN_GAP) / 2;
    localparam int CWS3 = (SCREEN_WIDTH - 2 * COLUMN_GAP) / 3;
    localparam int CWS4 = (SCREEN_WIDTH - 3 * COLUMN_GAP) / 4;
    localparam int CW1  = (CWS1 > 0) ? CWS1 : 1;
    localparam int CW2  = (CWS2 > 0) ? CWS2 : 1;
    localparam int CW3  = (CWS3 > 0) ? CWS3 : 1;
    localparam int CW4  = (CWS4 > 0) ? CWS4 : 1;
    localparam int D1   = (CW1 >= 2) ? CW1 - 1 : 1;
    localparam int D2   = (CW2 >= 2) ? CW2 - 1 : 1;
    localparam int D3   = (CW3 >= 2) ? CW3 - 1 : 1;
    localparam int D4   = (CW4 >= 2) ? CW4 - 1 : 1;

    localparam int XW0 = $clog2(MAX_COLS * (SCREEN_WIDTH + COLUMN_GAP) + 1);
    localparam int XCW = (XW0 > PIX_W) ? XW0 : PIX_W;
    localparam int YW0 = $clog2(SCREEN_HEIGHT + 1);
    localparam int YCW = (YW0 > PIX_W) ? YW0 : PIX_W;
    localparam int DW  = $clog2(SCREEN_WIDTH + 1);
    localparam int BH  = SCREEN_HEIGHT - MARKER_STRIP_ROWS;

    localparam logic [XCW-1:0] T_CW [MAX_COLS] =
        '{XCW'(CW1), XCW'(CW2), XCW'(CW3), XCW'(CW4)};
    localparam logic [XCW-1:0] T_PITCH [MAX_COLS] =
        '{XCW'(CW1 + COLUMN_GAP), XCW'(CW2 + COLUMN_GAP),
          XCW'(CW3 + COLUMN_GAP), XCW'(CW4 + COLUMN_GAP)};
    localparam logic T_OK [MAX_COLS] = '{CWS1 > 0, CWS2 > 0, CWS3 > 0, CWS4 > 0};
    localparam logic T_RAMP [MAX_COLS] = '{CW1 >= 2, CW2 >= 2, CW3 >= 2, CW4 >= 2};
    localparam logic [DW-1:0] T_D [MAX_COLS] = '{DW'(D1), DW'(D2), DW'(D3), DW'(D4)};
    localparam logic [RECIP_W-1:0] T_R [MAX_COLS] =
        '{RECIP_W'((1 << RAMP_SHIFT) / D1), RECIP_W'((1 << RAMP_SHIFT) / D2),
          RECIP_W'((1 << RAMP_SHIFT) / D3), RECIP_W'((1 << RAMP_SHIFT) / D4)};
    // first row of bands 1..4: MARKER + ceil(k*BH/5)
    localparam logic [YCW-1:0] T_BAND [BAND_COUNT-1] =
        '{YCW'(MARKER_STRIP_ROWS + (1 * BH + BAND_COUNT - 1) / BAND_COUNT),
          YCW'(MARKER_STRIP_ROWS + (2 * BH + BAND_COUNT - 1) / BAND_COUNT),
          YCW'(MARKER_STRIP_ROWS + (3 * BH + BAND_COUNT - 1) / BAND_COUNT),
          YCW'(MARKER_STRIP_ROWS + (4 * BH + BAND_COUNT - 1) / BAND_COUNT)};

    // configuration
    logic       r_depth;
    logic [1:0] r_nsel;     // column count minus one, clamped

    // pipeline control
    logic [NST:1] r_v;
    logic [NST:1] en;

    // stage 1
    logic [PIX_W-1:0] r1_x;
    logic [1:0]       r1_col;
    logic             r1_black, r1_top, r1_ymark;
    logic [2:0]       r1_band;
    // stage 2
    logic [PIX_W-1:0] r2_cx;
    logic [1:0]       r2_col;
    logic             r2_black, r2_top, r2_ymark;
    logic [2:0]       r2_band;
    // stage 3
    logic [NUM_W-1:0] r3_num;
    logic [1:0]       r3_col;
    logic             r3_black, r3_top, r3_mark;
    logic [2:0]       r3_band;
    // stage 4
    logic [CH_W-1:0]  r4_q;
    logic [NUM_W-1:0] r4_num;
    logic [1:0]       r4_col;
    logic             r4_black, r4_top, r4_mark;
    logic [2:0]       r4_band;
    // stage 5
    logic [NUM_W-1:0] r5_t;
    logic [CH_W-1:0]  r5_q;
    logic [NUM_W-1:0] r5_num;
    logic [1:0]       r5_col;
    logic             r5_black, r5_top, r5_mark;
    logic [2:0]       r5_band;
    // stage 6 (output)
    logic [BYTES_W-1:0] r6_bytes;
    t_rgb               r6_rgb;

    // ---- configuration port ----
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_16;
            r_nsel  <= 2'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DEPTH_MODE: r_depth <= i_cfg.data[0];
                REG_COLUMN_COUNT: begin
                    if (i_cfg.data == '0)
                        r_nsel <= 2'd0;
                    else if (i_cfg.data > CFG_DATA_W'(MAX_COLS))
                        r_nsel <= 2'(MAX_COLS - 1);
                    else
                        r_nsel <= 2'(i_cfg.data - CFG_DATA_W'(1));
                end
            endcase
        end
    end

    // ---- stage enables: a stage loads when empty or when it drains ----
    always_comb begin
        en[NST] = !r_v[NST] || o_pix.ready;
        for (int k = NST - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_pix.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) r_v[1] <= i_pix.valid;
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // ---- stage 1: column index, off-screen, band ----
    logic [XCW-1:0] s1_x, s1_p, s1_p2, s1_p3, s1_pn;
    logic [YCW-1:0] s1_y;
    logic [2:0]     s1_band;

    always_comb begin
        s1_x  = XCW'(i_pix.pixel_x);
        s1_y  = YCW'(i_pix.pixel_y);
        s1_p  = T_PITCH[r_nsel];
        s1_p2 = s1_p << 1;
        s1_p3 = s1_p + (s1_p << 1);
        case (r_nsel)
            2'd0: s1_pn = s1_p;
            2'd1: s1_pn = s1_p2;
            2'd2: s1_pn = s1_p3;
            default: s1_pn = s1_p << 2;
        endcase
        s1_band = '0;
        for (int k = 0; k < BAND_COUNT - 1; k++) begin
            if (s1_y >= T_BAND[k]) s1_band = s1_band + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_x     <= i_pix.pixel_x;
            r1_col   <= 2'(s1_x >= s1_p) + 2'(s1_x >= s1_p2) + 2'(s1_x >= s1_p3);
            r1_black <= (s1_x >= XCW'(SCREEN_WIDTH)) || (s1_y >= YCW'(SCREEN_HEIGHT)) ||
                        !T_OK[r_nsel] || (s1_x >= s1_pn);
            r1_top   <= s1_y < YCW'(MARKER_STRIP_ROWS);
            r1_ymark <= (s1_y >= YCW'(MARK_Y0)) && (s1_y < YCW'(MARK_Y1));
            r1_band  <= s1_band;
        end
    end

    // ---- stage 2: position within the column ----
    logic [XCW-1:0] s2_p, s2_off;

    always_comb begin
        s2_p = T_PITCH[r_nsel];
        case (r1_col)
            2'd0: s2_off = '0;
            2'd1: s2_off = s2_p;
            2'd2: s2_off = s2_p << 1;
            default: s2_off = s2_p + (s2_p << 1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_cx    <= PIX_W'(XCW'(r1_x) - s2_off);
            r2_col   <= r1_col;
            r2_black <= r1_black;
            r2_top   <= r1_top;
            r2_ymark <= r1_ymark;
            r2_band  <= r1_band;
        end
    end

    // ---- stage 3: gap test, marker squares, ramp numerator ----
    logic [PIX_W-1:0] s3_d;
    logic             s3_sq;

    always_comb begin
        s3_d  = r2_cx - PIX_W'(MARK_X0);
        s3_sq = 1'b0;
        // square k exists only for columns k and above
        for (int k = 0; k < MAX_COLS; k++) begin
            if ((2'(k) <= r2_col) && (s3_d >= PIX_W'(k * MARK_PITCH)) &&
                (s3_d < PIX_W'(k * MARK_PITCH + MARK_SIZE)))
                s3_sq = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_num   <= NUM_W'({r2_cx, 8'd0}) - NUM_W'(r2_cx);
            r3_col   <= r2_col;
            r3_black <= r2_black || (XCW'(r2_cx) >= T_CW[r_nsel]);
            r3_top   <= r2_top;
            r3_mark  <= r2_ymark && (r2_cx >= PIX_W'(MARK_X0)) && s3_sq;
            r3_band  <= r2_band;
        end
    end

    // ---- stage 4: quotient estimate, low by at most one ----
    logic [NUM_W+RECIP_W-1:0] s4_prod;

    assign s4_prod = (NUM_W + RECIP_W)'(r3_num) * (NUM_W + RECIP_W)'(T_R[r_nsel]);

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_q     <= s4_prod[RAMP_SHIFT +: CH_W];
            r4_num   <= r3_num;
            r4_col   <= r3_col;
            r4_black <= r3_black;
            r4_top   <= r3_top;
            r4_mark  <= r3_mark;
            r4_band  <= r3_band;
        end
    end

    // ---- stage 5: back multiply ----
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_t     <= NUM_W'(r4_q) * NUM_W'(T_D[r_nsel]);
            r5_q     <= r4_q;
            r5_num   <= r4_num;
            r5_col   <= r4_col;
            r5_black <= r4_black;
            r5_top   <= r4_top;
            r5_mark  <= r4_mark;
            r5_band  <= r4_band;
        end
    end

    // ---- stage 6: correct quotient, pick color, pack ----
    logic [NUM_W-1:0] s6_rem;
    t_chan            s6_ramp;
    t_rgb             s6_rgb;

    always_comb begin
        s6_rem  = r5_num - r5_t;
        s6_ramp = r5_q + CH_W'(s6_rem >= NUM_W'(T_D[r_nsel]));
        if (r5_black) begin
            s6_rgb = '0;
        end else if (r5_top) begin
            s6_rgb = r5_mark ? '{red: CHAN_FULL, green: CHAN_FULL, blue: CHAN_FULL} : '0;
        end else if (r5_band != 3'(BAND_COUNT - 1)) begin
            s6_rgb = band_color(r5_band[1:0]);
        end else if (T_RAMP[r_nsel]) begin
            s6_rgb = '{red: s6_ramp, green: s6_ramp, blue: s6_ramp};
        end else begin
            s6_rgb = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r6_rgb   <= s6_rgb;
            r6_bytes <= pack_pixel(r_depth, r5_col, s6_rgb);
        end
    end

    assign o_pix.valid       = r_v[NST];
    assign o_pix.pixel_bytes = r6_bytes;
    assign o_pix.red         = r6_rgb.red;
    assign o_pix.green       = r6_rgb.green;
    assign o_pix.blue        = r6_rgb.blue;

endmodule

// File: design/botp_chk.sv
// ----------------------------------------------------------------------------
// botp_chk - port checker for the test pattern pixel block
// Watches handshakes and output consistency; bound to the top level.
// ----------------------------------------------------------------------------
module botp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_bytes,
    input logic [7:0]  i_red,
    input logic [7:0]  i_green,
    input logic [7:0]  i_blue
);

    // nothing comes out of reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // an empty output stage always lets a new item in
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // black packs to all-zero bytes in every mode and column
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_red == 8'd0 && i_green == 8'd0 && i_blue == 8'd0)
        |-> (i_out_bytes == 32'd0))
        else $error("black item with nonzero bytes");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("stalled item dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        ($stable(i_out_bytes) && $stable(i_red) && $stable(i_green) && $stable(i_blue)))
        else $error("stalled item changed");

endmodule

bind byte_order_test_pattern_pixel botp_chk u_botp_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_pix.valid),
    .i_in_ready (i_pix.ready),
    .i_out_valid(o_pix.valid),
    .i_out_ready(o_pix.ready),
    .i_out_bytes(o_pix.pixel_bytes),
    .i_red      (o_pix.red),
    .i_green    (o_pix.green),
    .i_blue     (o_pix.blue)
);
